// ----- hw/rtl/ntd_pkg.sv -----
package ntd_pkg;

  // Clock and arithmetic widths
  localparam int unsigned CLOCK_HZ = 64000000;
  localparam int DIV_W  = $clog2(CLOCK_HZ + 1);
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int HZ_W   = 10;
  localparam int PRE_W  = 16;
  localparam int DSR_W  = HZ_W + PRE_W + 1;
  localparam int PER_W  = 21;
  localparam int CMP_W  = 20;
  localparam int CHAR_W = 8;
  localparam int OCT_W  = 3;

  localparam logic [DIV_W-1:0] DIVIDEND     = DIV_W'(CLOCK_HZ);
  localparam logic [DIV_W-1:0] PERIOD_MAX   = DIV_W'((1 << PER_W) - 1);
  localparam logic [PRE_W-1:0] PRESCALE_RST = PRE_W'(9);

  // One queued note: frequency or silence
  typedef struct packed {
    logic            silent;
    logic [HZ_W-1:0] hz;
  } tone_tok_t;

endpackage

// ----- hw/rtl/note_string_tone_divider.sv -----
// Path from an input beat that completes a note to its result: queue write, dequeue,
// multiply, 26 restoring divide steps, result register (held while out_ready_i is low).
// The shared bit-serial divider handles one note at a time; others wait in the queue.
// Silent notes skip multiply and divide; an octave digit with none pending gives no result.
// Reset (rst_ni low, asynchronous): no octave pending, queue and result empty,
// prescale = 9.
module note_string_tone_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ntd_pkg::PRE_W-1:0]   cfg_prescale_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ntd_pkg::CHAR_W-1:0]  char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ntd_pkg::HZ_W-1:0]    tone_hz_o,
  output logic [ntd_pkg::PER_W-1:0]   period_word_o,
  output logic [ntd_pkg::CMP_W-1:0]   compare_word_o,
  output logic                        silent_o
);

  logic [ntd_pkg::PRE_W-1:0] prescale_q;
  logic                      q_push, q_pop, q_full, q_empty;
  ntd_pkg::tone_tok_t        push_tok, pop_tok;

  // Prescale register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= ntd_pkg::PRESCALE_RST;
    end else if (cfg_valid_i) begin
      prescale_q <= cfg_prescale_i;
    end
  end

  ntd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_tok_o     (push_tok)
  );

  ntd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_tok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (pop_tok),
    .empty_o (q_empty)
  );

  ntd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .prescale_i     (prescale_q),
    .q_empty_i      (q_empty),
    .q_tok_i        (pop_tok),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tone_hz_o      (tone_hz_o),
    .period_word_o  (period_word_o),
    .compare_word_o (compare_word_o),
    .silent_o       (silent_o)
  );

endmodule

// ----- hw/rtl/ntd_front.sv -----
module ntd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ntd_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output ntd_pkg::tone_tok_t           q_tok_o
);

  localparam logic [ntd_pkg::CHAR_W-1:0] CHAR_ONE  = 8'h31;
  localparam logic [ntd_pkg::CHAR_W-1:0] CHAR_FIVE = 8'h35;
  localparam logic [ntd_pkg::CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [3:0] SLOT_NONE = 4'd15;

  localparam logic [ntd_pkg::HZ_W-1:0] NOTE_HZ [60] = '{
    10'd33,  10'd35,  10'd37,  10'd39,  10'd41,  10'd44,
    10'd46,  10'd49,  10'd52,  10'd55,  10'd58,  10'd62,
    10'd65,  10'd69,  10'd73,  10'd78,  10'd82,  10'd87,
    10'd93,  10'd98,  10'd104, 10'd110, 10'd117, 10'd123,
    10'd131, 10'd139, 10'd147, 10'd156, 10'd165, 10'd175,
    10'd185, 10'd196, 10'd208, 10'd220, 10'd233, 10'd247,
    10'd262, 10'd277, 10'd294, 10'd311, 10'd330, 10'd349,
    10'd370, 10'd392, 10'd415, 10'd440, 10'd466, 10'd494,
    10'd523, 10'd554, 10'd587, 10'd622, 10'd659, 10'd698,
    10'd740, 10'd784, 10'd831, 10'd880, 10'd932, 10'd988
  };

  logic [ntd_pkg::OCT_W-1:0] oct_q, oct_d;
  logic                      beat;
  logic                      is_digit;
  logic [3:0]                slot;
  logic [5:0]                row;
  logic [5:0]                idx;

  // Note letter to semitone slot
  always_comb begin
    unique case (char_code_i)
      8'h63:   slot = 4'd0;
      8'h43:   slot = 4'd1;
      8'h64:   slot = 4'd2;
      8'h44:   slot = 4'd3;
      8'h65:   slot = 4'd4;
      8'h66:   slot = 4'd5;
      8'h46:   slot = 4'd6;
      8'h67:   slot = 4'd7;
      8'h47:   slot = 4'd8;
      8'h61:   slot = 4'd9;
      8'h41:   slot = 4'd10;
      8'h62:   slot = 4'd11;
      default: slot = SLOT_NONE;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign beat       = in_valid_i && in_ready_o;
  assign is_digit   = (char_code_i >= CHAR_ONE) && (char_code_i <= CHAR_FIVE);

  // Table index: (octave - 1) * 12 + slot
  assign row = 6'({3'b000, oct_q} - 6'd1);
  assign idx = (row << 3) + (row << 2) + {2'b00, slot};

  // Classify the beat and build the token
  always_comb begin
    oct_d          = oct_q;
    q_push_o       = 1'b0;
    q_tok_o.silent = 1'b1;
    q_tok_o.hz     = '0;
    if (beat) begin
      if (oct_q == '0) begin
        if (is_digit) begin
          oct_d = ntd_pkg::OCT_W'(char_code_i - CHAR_ZERO);
        end else begin
          q_push_o = 1'b1;
        end
      end else begin
        q_push_o = 1'b1;
        oct_d    = '0;
        if (slot != SLOT_NONE) begin
          q_tok_o.silent = 1'b0;
          q_tok_o.hz     = NOTE_HZ[idx];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q <= '0;
    end else begin
      oct_q <= oct_d;
    end
  end

endmodule

// ----- hw/rtl/ntd_fifo.sv -----
module ntd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ntd_pkg::tone_tok_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output ntd_pkg::tone_tok_t  data_o,
  output logic                empty_o
);

  ntd_pkg::tone_tok_t mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/ntd_back.sv -----
module ntd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ntd_pkg::PRE_W-1:0]   prescale_i,
  input  logic                        q_empty_i,
  input  ntd_pkg::tone_tok_t          q_tok_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ntd_pkg::HZ_W-1:0]    tone_hz_o,
  output logic [ntd_pkg::PER_W-1:0]   period_word_o,
  output logic [ntd_pkg::CMP_W-1:0]   compare_word_o,
  output logic                        silent_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                            state_q;
  ntd_pkg::tone_tok_t                tok_q;
  logic [ntd_pkg::DSR_W-1:0]         dsr_q;
  logic [ntd_pkg::DSR_W-1:0]         rem_q;
  logic [ntd_pkg::DIV_W-1:0]         quo_q;
  logic [ntd_pkg::CNT_W-1:0]         cnt_q;
  logic                              out_valid_q;
  logic [ntd_pkg::HZ_W-1:0]          hz_q;
  logic [ntd_pkg::PER_W-1:0]         per_q;
  logic [ntd_pkg::CMP_W-1:0]         cmp_q;
  logic                              sil_q;

  logic [ntd_pkg::DSR_W:0]           trial;
  logic                              fits;
  logic [ntd_pkg::DIV_W-1:0]         per_full;
  logic [ntd_pkg::DIV_W-1:0]         per_sat;
  logic                              out_free;
  logic [ntd_pkg::DSR_W-1:0]         product;

  // One radix-2 restoring step
  assign trial = {rem_q, ntd_pkg::DIVIDEND[cnt_q]};
  assign fits  = trial >= {1'b0, dsr_q};

  // Divisor: hz * (prescale + 1)
  assign product = ntd_pkg::DSR_W'(tok_q.hz) *
                   ntd_pkg::DSR_W'({1'b0, prescale_i} + 17'd1);

  // Quotient to reload word with saturation
  assign per_full = (quo_q == '0) ? '0 : quo_q - ntd_pkg::DIV_W'(1);
  assign per_sat  = (per_full > ntd_pkg::PERIOD_MAX) ? ntd_pkg::PERIOD_MAX : per_full;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  assign out_valid_o    = out_valid_q;
  assign tone_hz_o      = hz_q;
  assign period_word_o  = per_q;
  assign compare_word_o = cmp_q;
  assign silent_o       = sil_q;

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tok_q       <= '0;
      dsr_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      hz_q        <= '0;
      per_q       <= '0;
      cmp_q       <= '0;
      sil_q       <= 1'b0;
    end else begin
      // in ST_DONE the result register reloads valid itself
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            tok_q   <= q_tok_i;
            state_q <= q_tok_i.silent ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          dsr_q   <= product;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= ntd_pkg::CNT_W'(ntd_pkg::DIV_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= fits ? ntd_pkg::DSR_W'(trial - {1'b0, dsr_q})
                        : ntd_pkg::DSR_W'(trial);
          quo_q <= {quo_q[ntd_pkg::DIV_W-2:0], fits};
          cnt_q <= cnt_q - ntd_pkg::CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (tok_q.silent) begin
              hz_q  <= '0;
              per_q <= '0;
              cmp_q <= '0;
              sil_q <= 1'b1;
            end else begin
              hz_q  <= tok_q.hz;
              per_q <= per_sat[ntd_pkg::PER_W-1:0];
              cmp_q <= per_sat[ntd_pkg::PER_W-1:1];
              sil_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
